// File: rtl/assert_macros.svh
// assertion macros shared by the scanner modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LMSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// consequent checked in the cycle after the antecedent
`define LMSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: rtl/lmss_pkg.sv
// shared constants, types and the glyph reset table of the matrix scanner
package lmss_pkg;

  localparam int unsigned GLYPH_SLOTS = 16;
  localparam int unsigned SLOT_W      = $clog2(GLYPH_SLOTS);
  localparam int unsigned STORE_DEPTH = GLYPH_SLOTS * 8;
  localparam int unsigned ADDR_W      = SLOT_W + 3;
  // slot numbers wide enough for index + 1 and for the slot count itself
  localparam int unsigned SLOT_CMP_W  = 7;
  localparam int unsigned CFG_IDX_W   = 8;

  localparam logic [15:0]           PERIOD_RESET = 16'd500;
  localparam logic [3:0]            COUNT_RESET  = 4'd11;
  localparam logic [SLOT_CMP_W-1:0] SLOT_LIMIT   = SLOT_CMP_W'(GLYPH_SLOTS);

  typedef logic [ADDR_W-1:0] store_addr_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCROLL_PERIOD = 8'd0,
    CFG_CHAR_COUNT    = 8'd1
  } cfg_reg_e;

  // position of the row to be drawn, as seen by the datapath
  typedef struct packed {
    logic [2:0] row;
    logic [3:0] idx;
    logic [2:0] off;
    logic       all_on;
  } tick_cmd_t;

  // row waiting for its glyph bytes
  typedef struct packed {
    logic       valid;
    logic [2:0] row;
    logic [2:0] off;
    logic       all_on;
    logic       in_a;
    logic       in_b;
  } stage_t;

  localparam logic [7:0] DIGIT_ROWS [0:3][0:7] = '{
    '{8'h40, 8'hC0, 8'h40, 8'h40, 8'h40, 8'h40, 8'hE0, 8'h06},
    '{8'h70, 8'h88, 8'h08, 8'h10, 8'h20, 8'h40, 8'hF8, 8'h06},
    '{8'hF8, 8'h10, 8'h20, 8'h10, 8'h08, 8'h88, 8'h70, 8'h06},
    '{8'h10, 8'h30, 8'h50, 8'h90, 8'hF8, 8'h10, 8'h10, 8'h06}
  };

  // content of a store entry that was never loaded
  function automatic logic [7:0] glyph_init(input store_addr_t addr);
    logic [SLOT_CMP_W-1:0] slot;
    logic [1:0]            digit;
    logic [7:0]            res;
    slot  = SLOT_CMP_W'(addr >> 3);
    digit = 2'(slot - SLOT_CMP_W'(1));
    res   = 8'h00;
    if (slot >= SLOT_CMP_W'(1) && slot <= SLOT_CMP_W'(4) && slot < SLOT_LIMIT) begin
      res = DIGIT_ROWS[digit][addr[2:0]];
    end
    return res;
  endfunction

endpackage

// File: rtl/lmss_glyph_ram.sv
// glyph store: one write port, two registered read ports, per-entry loaded bits
module lmss_glyph_ram (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  lmss_pkg::store_addr_t wr_addr_i,
  input  logic [7:0]           wr_data_i,
  input  logic                 rd_en_i,
  input  lmss_pkg::store_addr_t rd_addr_a_i,
  input  lmss_pkg::store_addr_t rd_addr_b_i,
  output logic [7:0]           rd_data_a_o,
  output logic [7:0]           rd_data_b_o
);
  import lmss_pkg::*;

  logic [7:0]             mem_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] loaded_q;
  logic [7:0]             rd_a_q, rd_b_q;
  store_addr_t            ra_q, rb_q;
  logic                   ld_a_q, ld_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
      ra_q   <= rd_addr_a_i;
      rb_q   <= rd_addr_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      ld_a_q   <= 1'b0;
      ld_b_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        loaded_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        ld_a_q <= loaded_q[rd_addr_a_i];
        ld_b_q <= loaded_q[rd_addr_b_i];
      end
    end
  end

  // entries never loaded show their power-up glyph
  assign rd_data_a_o = ld_a_q ? rd_a_q : glyph_init(ra_q);
  assign rd_data_b_o = ld_b_q ? rd_b_q : glyph_init(rb_q);

endmodule

// File: rtl/lmss_scan_ctrl.sv
// scroll timing, row counter and configuration registers
`include "assert_macros.svh"

module lmss_scan_ctrl (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lmss_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [15:0]                            cfg_data_i,
  input  logic                                   tick_i,
  output lmss_pkg::tick_cmd_t                    cmd_o
);
  import lmss_pkg::*;

  logic [15:0] period_q, period_d;
  logic [3:0]  char_count_q, char_count_d;
  logic [2:0]  scan_row_q, scan_row_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [2:0]  step_off_q, step_off_d;
  logic [3:0]  step_idx_q, step_idx_d;
  logic [2:0]  shown_off_q, shown_off_d;
  logic [3:0]  shown_idx_q, shown_idx_d;
  logic        all_on_q, all_on_d;

  logic        fire;
  logic [15:0] elapsed_base;
  logic [2:0]  off_inc;
  logic [4:0]  idx_inc;

  assign fire = (scan_row_q == 3'd0) && (elapsed_q >= period_q);

  always_comb begin
    cmd_o.row    = scan_row_q;
    cmd_o.idx    = fire ? step_idx_q : shown_idx_q;
    cmd_o.off    = fire ? step_off_q : shown_off_q;
    cmd_o.all_on = fire ? 1'b0 : all_on_q;
  end

  always_comb begin
    period_d     = period_q;
    char_count_d = char_count_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCROLL_PERIOD: period_d     = cfg_data_i;
        CFG_CHAR_COUNT:    char_count_d = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    off_inc      = step_off_q + 3'd1;
    idx_inc      = {1'b0, step_idx_q} + 5'd1;
    elapsed_base = fire ? 16'd0 : elapsed_q;
    scan_row_d   = scan_row_q;
    elapsed_d    = elapsed_q;
    step_off_d   = step_off_q;
    step_idx_d   = step_idx_q;
    shown_off_d  = shown_off_q;
    shown_idx_d  = shown_idx_q;
    all_on_d     = all_on_q;
    if (tick_i) begin
      scan_row_d = scan_row_q + 3'd1;
      // counter saturates instead of wrapping
      elapsed_d  = (elapsed_base != 16'hFFFF) ? elapsed_base + 16'd1 : elapsed_base;
      if (fire) begin
        shown_off_d = step_off_q;
        shown_idx_d = step_idx_q;
        all_on_d    = 1'b0;
        step_off_d  = off_inc;
        if (off_inc == 3'd0) begin
          step_idx_d = (idx_inc > {1'b0, char_count_q}) ? 4'd0 : idx_inc[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= PERIOD_RESET;
      char_count_q <= COUNT_RESET;
      scan_row_q   <= 3'd0;
      elapsed_q    <= 16'd0;
      step_off_q   <= 3'd0;
      step_idx_q   <= 4'd0;
      shown_off_q  <= 3'd0;
      shown_idx_q  <= 4'd0;
      all_on_q     <= 1'b1;
    end else begin
      period_q     <= period_d;
      char_count_q <= char_count_d;
      scan_row_q   <= scan_row_d;
      elapsed_q    <= elapsed_d;
      step_off_q   <= step_off_d;
      step_idx_q   <= step_idx_d;
      shown_off_q  <= shown_off_d;
      shown_idx_q  <= shown_idx_d;
      all_on_q     <= all_on_d;
    end
  end

  `LMSS_ASSERT_NEXT(a_row_advances, tick_i, scan_row_q == 3'($past(scan_row_q) + 3'd1))
  `LMSS_ASSERT_NEXT(a_step_restarts, tick_i && fire, elapsed_q == 16'd1 && !all_on_q)
  `LMSS_ASSERT_NEXT(a_idle_holds, !tick_i, $stable(shown_idx_q) && $stable(step_idx_q))

endmodule

// File: rtl/led_matrix_scroll_scanner_core.sv
// top level of the scrolling 8x8 led matrix scanner
`include "assert_macros.svh"

// Each request on the slave stream is either a scan tick (tuser = 0), which
// produces one matrix row on the master stream, or a glyph store load
// (tuser = 1), which writes one bitmap byte and produces nothing. One
// request is taken per clock cycle unless a staged row waits on a stalled
// output. A tick is read as the two neighboring glyph bytes from the dual
// read port glyph store, then the shifted pixel byte is formed into the
// output register. The store needs no clearing pass: entries never loaded
// read as power-up glyphs, blank but for digits in slots 1 to 4. Configuration
// writes are taken in any cycle and are meant for times with no row in flight.
module led_matrix_scroll_scanner_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] glyph_slot, [6:4] glyph_row, [14:7] glyph_bits, [15] zero
  input  logic [15:0]                    s_axis_tdata,
  // [0] op
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] row_select, [15:8] row_pixels
  output logic [15:0]                    m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lmss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);
  import lmss_pkg::*;

  logic        advance, in_acc, tick_acc, load_acc;
  logic        wr_en;
  tick_cmd_t   cmd;
  stage_t      st_q, st_d;
  logic [SLOT_CMP_W-1:0] slot_a, slot_b, wr_slot;
  store_addr_t rd_addr_a, rd_addr_b, wr_addr;
  logic [7:0]  byte_a, byte_b;
  logic [15:0] window;
  logic [7:0]  pixels;

  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic        out_last_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !st_q.valid || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign tick_acc      = in_acc && (op_e'(s_axis_tuser) == OP_TICK);
  assign load_acc      = in_acc && (op_e'(s_axis_tuser) == OP_LOAD);
  assign cfg_ready_o   = 1'b1;

  lmss_scan_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tick_i      (tick_acc),
    .cmd_o       (cmd)
  );

  // glyph pair for the row, slot past the end reads blank
  assign slot_a    = SLOT_CMP_W'(cmd.idx);
  assign slot_b    = slot_a + SLOT_CMP_W'(1);
  assign rd_addr_a = {slot_a[SLOT_W-1:0], cmd.row};
  assign rd_addr_b = {slot_b[SLOT_W-1:0], cmd.row};

  assign wr_slot = SLOT_CMP_W'(s_axis_tdata[3:0]);
  assign wr_addr = {wr_slot[SLOT_W-1:0], s_axis_tdata[6:4]};
  assign wr_en   = load_acc && (wr_slot < SLOT_LIMIT);

  lmss_glyph_ram u_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (s_axis_tdata[14:7]),
    .rd_en_i     (tick_acc),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (byte_a),
    .rd_data_b_o (byte_b)
  );

  always_comb begin
    st_d = st_q;
    if (tick_acc) begin
      st_d.valid  = 1'b1;
      st_d.row    = cmd.row;
      st_d.off    = cmd.off;
      st_d.all_on = cmd.all_on;
      st_d.in_a   = slot_a < SLOT_LIMIT;
      st_d.in_b   = slot_b < SLOT_LIMIT;
    end else if (advance) begin
      st_d.valid  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  // right shift of the glyph pair keeps both halves of the window
  assign window = {st_q.in_b ? byte_b : 8'h00, st_q.in_a ? byte_a : 8'h00} >> st_q.off;
  assign pixels = st_q.all_on ? 8'hFF : window[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= st_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && st_q.valid) begin
      out_data_q <= {pixels, ~(8'd1 << st_q.row)};
      out_last_q <= (st_q.row == 3'd7);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `LMSS_ASSERT(a_stall_blocks, (out_valid_q && !m_axis_tready && st_q.valid) |-> !s_axis_tready)
  `LMSS_ASSERT_NEXT(a_tick_staged, tick_acc, st_q.valid)
  `LMSS_ASSERT_NEXT(a_load_silent, load_acc && !st_q.valid && advance, !st_q.valid)

endmodule
